FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

FILE: hdl/rlgd_pkg.sv
// Types and constants of the RSSI lap gate detector.
`default_nettype none

package rlgd_pkg;

    localparam int RSSI_W = 8;
    localparam int TIME_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_LAP_SLOTS = 16;
    localparam int DEF_CAL_PASSES = 4;

    localparam logic [TIME_W-1:0] PASS_COOLDOWN_MS = 32'd2000;
    localparam logic [RSSI_W-1:0] PASS_DROP_MARGIN = 8'd5;
    localparam logic [RSSI_W-1:0] ENTER_FALLBACK = 8'd5;
    localparam logic [RSSI_W-1:0] EXIT_FALLBACK = 8'd10;
    localparam logic [RSSI_W-1:0] RSSI_MAX = 8'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_RSSI = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_RSSI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAP_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MARGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_ENTER_OFS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_EXIT_OFS = 3'd5;

    typedef enum logic [2:0] {
        KIND_SAMPLE     = 3'd0,
        KIND_START_RACE = 3'd1,
        KIND_STOP_RACE  = 3'd2,
        KIND_START_CAL  = 3'd3,
        KIND_STOP_CAL   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CAL_IDLE   = 2'd0,
        CAL_ACTIVE = 2'd1,
        CAL_DONE   = 2'd2
    } t_cal_mode;

    typedef struct packed {
        logic [2:0]        kind;
        logic [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0] time_ms;
    } t_item;

    typedef struct packed {
        logic              lap_done;
        logic [TIME_W-1:0] lap_time_ms;
        logic [3:0]        lap_slot;
        logic              running;
        logic [1:0]        autocal_mode;
        logic [2:0]        autocal_passes;
        logic [RSSI_W-1:0] baseline_rssi;
        logic [RSSI_W-1:0] calc_enter;
        logic [RSSI_W-1:0] calc_exit;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/rssi_lap_gate_detector_unit.sv
// Top level of the RSSI lap gate detector: race timing, peak capture and auto-calibration.
//
// Takes one beat per clock unless o_in_stall is high: a timestamped RSSI sample or a
// command, and returns exactly one result beat for each, registered into the output
// register or, while it is held, the skid register. All state updates are a single
// pass of compare/subtract logic at the input, so the sustained rate is one item per
// cycle while results are taken; o_in_stall rises only while both hold untaken results.
// Configuration writes are taken every cycle (o_cfg_ready is always high) and must only be
// issued while no result is outstanding. No clearing pass is needed after reset.
`default_nettype none

`include "assert_macros.svh"

module rssi_lap_gate_detector_unit #(
    parameter int LAP_SLOTS  = rlgd_pkg::DEF_LAP_SLOTS,
    parameter int CAL_PASSES = rlgd_pkg::DEF_CAL_PASSES
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire rlgd_pkg::t_item                  i_in_data,

    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output rlgd_pkg::t_result                     o_out_data,

    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [rlgd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rlgd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SLOT_W = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;
    localparam int CNT_W  = $clog2(CAL_PASSES + 1);
    localparam int RW     = rlgd_pkg::RSSI_W;
    localparam int TW     = rlgd_pkg::TIME_W;

    // configuration
    logic [RW-1:0] r_enter_rssi, r_exit_rssi, r_cal_margin, r_cal_enter_ofs, r_cal_exit_ofs;
    logic [TW-1:0] r_min_lap_ms;

    // race state
    logic              r_running, n_running;
    logic [TW-1:0]     r_race_start, n_race_start;
    logic [TW-1:0]     r_lap_start, n_lap_start;
    logic [RW-1:0]     r_peak_level, n_peak_level;
    logic [TW-1:0]     r_peak_time, n_peak_time;
    logic [SLOT_W-1:0] r_lap_cnt, n_lap_cnt;
    logic              r_wrapped, n_wrapped;

    // calibration state; only the lowest stored pass peak is ever needed
    rlgd_pkg::t_cal_mode r_cal_mode, n_cal_mode;
    logic [CNT_W-1:0]    r_cal_cnt, n_cal_cnt;
    logic [RW-1:0]       r_cal_base, n_cal_base;
    logic                r_cal_seen, n_cal_seen;
    logic [TW-1:0]       r_cal_last, n_cal_last;
    logic [RW-1:0]       r_cal_low, n_cal_low;

    // output buffer
    logic              r_out_valid, r_skid_valid;
    rlgd_pkg::t_result r_out, r_skid, n_res;

    logic in_accept, out_free;

    // datapath intermediates
    logic [RW-1:0]  base_min, detect, cal_peak_lvl;
    logic [RW:0]    detect_sum, drop_lim;
    logic           cal_peak_hit, cal_seen, cal_store;
    logic [CNT_W-1:0] cal_cnt_inc;
    logic           race_hit, lap_end, first_lap;
    logic [RW-1:0]  race_peak;
    logic [TW-1:0]  race_ptime;
    logic           lap_done;
    logic [TW-1:0]  lap_time;
    logic [SLOT_W-1:0] lap_slot;
    logic [RW-1:0]  calc_enter, calc_exit;

    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // calibration sample path
    assign base_min     = (i_in_data.rssi < r_cal_base) ? i_in_data.rssi : r_cal_base;
    assign detect_sum   = {1'b0, base_min} + {1'b0, r_cal_margin};
    assign detect       = detect_sum[RW] ? rlgd_pkg::RSSI_MAX : detect_sum[RW-1:0];
    assign cal_peak_hit = (i_in_data.rssi > detect) && (i_in_data.rssi > r_peak_level);
    assign cal_peak_lvl = cal_peak_hit ? i_in_data.rssi : r_peak_level;
    assign cal_seen     = cal_peak_hit || r_cal_seen;
    assign drop_lim     = {1'b0, base_min} + {1'b0, rlgd_pkg::PASS_DROP_MARGIN};
    assign cal_cnt_inc  = r_cal_cnt + CNT_W'(1);
    assign cal_store    = cal_seen
                       && ({1'b0, i_in_data.rssi} < drop_lim)
                       && ((i_in_data.time_ms - r_cal_last) > rlgd_pkg::PASS_COOLDOWN_MS)
                       && (r_cal_cnt < CNT_W'(CAL_PASSES))
                       && (cal_peak_lvl != '0);

    // race sample path; hold-off measured from lap start
    assign race_hit   = ((i_in_data.time_ms - r_lap_start) > r_min_lap_ms)
                     && (i_in_data.rssi >= r_enter_rssi)
                     && (i_in_data.rssi > r_peak_level);
    assign race_peak  = race_hit ? i_in_data.rssi : r_peak_level;
    assign race_ptime = race_hit ? i_in_data.time_ms : r_peak_time;
    assign lap_end    = (i_in_data.rssi < race_peak) && (i_in_data.rssi < r_exit_rssi);
    assign first_lap  = (r_lap_cnt == '0) && !r_wrapped;

    // next state of race and calibration registers
    always_comb begin
        n_running    = r_running;
        n_race_start = r_race_start;
        n_lap_start  = r_lap_start;
        n_peak_level = r_peak_level;
        n_peak_time  = r_peak_time;
        n_lap_cnt    = r_lap_cnt;
        n_wrapped    = r_wrapped;
        n_cal_cnt    = r_cal_cnt;
        n_cal_base   = r_cal_base;
        n_cal_seen   = r_cal_seen;
        n_cal_last   = r_cal_last;
        n_cal_low    = r_cal_low;
        lap_done     = 1'b0;
        lap_time     = '0;
        lap_slot     = '0;
        if (in_accept) begin
            case (i_in_data.kind)
                rlgd_pkg::KIND_SAMPLE: begin
                    if (r_cal_mode == rlgd_pkg::CAL_ACTIVE) begin
                        n_cal_base = base_min;
                        if (cal_store) begin
                            n_cal_cnt    = cal_cnt_inc;
                            n_cal_last   = i_in_data.time_ms;
                            n_cal_low    = (cal_peak_lvl < r_cal_low) ? cal_peak_lvl
                                                                      : r_cal_low;
                            n_peak_level = '0;
                            n_peak_time  = '0;
                            n_cal_seen   = 1'b0;
                        end else begin
                            n_peak_level = cal_peak_lvl;
                            n_peak_time  = cal_peak_hit ? i_in_data.time_ms : r_peak_time;
                            n_cal_seen   = cal_seen;
                        end
                    end else if (r_running) begin
                        if (lap_end) begin
                            lap_done     = 1'b1;
                            lap_time     = race_ptime - (first_lap ? r_race_start
                                                                   : r_lap_start);
                            lap_slot     = r_lap_cnt;
                            if (r_lap_cnt == SLOT_W'(LAP_SLOTS - 1)) begin
                                n_lap_cnt = '0;
                                n_wrapped = 1'b1;
                            end else begin
                                n_lap_cnt = r_lap_cnt + SLOT_W'(1);
                            end
                            n_lap_start  = race_ptime;
                            n_peak_level = '0;
                            n_peak_time  = '0;
                        end else begin
                            n_peak_level = race_peak;
                            n_peak_time  = race_ptime;
                        end
                    end
                end
                rlgd_pkg::KIND_START_RACE: begin
                    n_race_start = i_in_data.time_ms;
                    n_running    = 1'b1;
                end
                rlgd_pkg::KIND_STOP_RACE: begin
                    n_running    = 1'b0;
                    n_wrapped    = 1'b0;
                    n_lap_cnt    = '0;
                    n_race_start = '0;
                    n_lap_start  = '0;
                    n_peak_level = '0;
                    n_peak_time  = '0;
                end
                rlgd_pkg::KIND_START_CAL: begin
                    n_cal_cnt    = '0;
                    n_cal_base   = rlgd_pkg::RSSI_MAX;
                    n_cal_seen   = 1'b0;
                    n_cal_last   = '0;
                    n_cal_low    = rlgd_pkg::RSSI_MAX;
                    n_peak_level = '0;
                end
                rlgd_pkg::KIND_STOP_CAL: begin
                    n_cal_cnt  = '0;
                    n_cal_seen = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // calibration mode next state
    always_comb begin
        n_cal_mode = r_cal_mode;
        if (in_accept) begin
            case (i_in_data.kind)
                rlgd_pkg::KIND_SAMPLE: begin
                    if (r_cal_mode == rlgd_pkg::CAL_ACTIVE && cal_store &&
                        cal_cnt_inc >= CNT_W'(CAL_PASSES)) begin
                        n_cal_mode = rlgd_pkg::CAL_DONE;
                    end
                end
                rlgd_pkg::KIND_START_CAL: n_cal_mode = rlgd_pkg::CAL_ACTIVE;
                rlgd_pkg::KIND_STOP_CAL:  n_cal_mode = rlgd_pkg::CAL_IDLE;
                default: begin
                end
            endcase
        end
    end

    // thresholds from the lowest pass peak; fall back to fixed offsets when too small
    always_comb begin
        if (n_cal_cnt == '0) begin
            calc_enter = '0;
        end else if (n_cal_low > r_cal_enter_ofs) begin
            calc_enter = n_cal_low - r_cal_enter_ofs;
        end else if (n_cal_low > rlgd_pkg::ENTER_FALLBACK) begin
            calc_enter = n_cal_low - rlgd_pkg::ENTER_FALLBACK;
        end else begin
            calc_enter = '0;
        end
        if (calc_enter > r_cal_exit_ofs) begin
            calc_exit = calc_enter - r_cal_exit_ofs;
        end else if (calc_enter > rlgd_pkg::EXIT_FALLBACK) begin
            calc_exit = calc_enter - rlgd_pkg::EXIT_FALLBACK;
        end else begin
            calc_exit = '0;
        end
    end

    // result beat
    always_comb begin
        n_res.lap_done       = lap_done;
        n_res.lap_time_ms    = lap_time;
        n_res.lap_slot       = 4'(lap_slot);
        n_res.running        = n_running;
        n_res.autocal_mode   = n_cal_mode;
        n_res.autocal_passes = 3'(n_cal_cnt);
        n_res.baseline_rssi  = n_cal_base;
        n_res.calc_enter     = calc_enter;
        n_res.calc_exit      = calc_exit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_rssi    <= 8'd120;
            r_exit_rssi     <= 8'd100;
            r_min_lap_ms    <= 32'd5000;
            r_cal_margin    <= 8'd20;
            r_cal_enter_ofs <= 8'd5;
            r_cal_exit_ofs  <= 8'd10;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rlgd_pkg::CFG_ENTER_RSSI:    r_enter_rssi    <= i_cfg_data[RW-1:0];
                rlgd_pkg::CFG_EXIT_RSSI:     r_exit_rssi     <= i_cfg_data[RW-1:0];
                rlgd_pkg::CFG_MIN_LAP_MS:    r_min_lap_ms    <= i_cfg_data[TW-1:0];
                rlgd_pkg::CFG_CAL_MARGIN:    r_cal_margin    <= i_cfg_data[RW-1:0];
                rlgd_pkg::CFG_CAL_ENTER_OFS: r_cal_enter_ofs <= i_cfg_data[RW-1:0];
                rlgd_pkg::CFG_CAL_EXIT_OFS:  r_cal_exit_ofs  <= i_cfg_data[RW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_race_start <= '0;
            r_lap_start  <= '0;
            r_peak_level <= '0;
            r_peak_time  <= '0;
            r_lap_cnt    <= '0;
            r_wrapped    <= 1'b0;
            r_cal_mode   <= rlgd_pkg::CAL_IDLE;
            r_cal_cnt    <= '0;
            r_cal_base   <= rlgd_pkg::RSSI_MAX;
            r_cal_seen   <= 1'b0;
            r_cal_last   <= '0;
            r_cal_low    <= rlgd_pkg::RSSI_MAX;
        end else begin
            r_running    <= n_running;
            r_race_start <= n_race_start;
            r_lap_start  <= n_lap_start;
            r_peak_level <= n_peak_level;
            r_peak_time  <= n_peak_time;
            r_lap_cnt    <= n_lap_cnt;
            r_wrapped    <= n_wrapped;
            r_cal_mode   <= n_cal_mode;
            r_cal_cnt    <= n_cal_cnt;
            r_cal_base   <= n_cal_base;
            r_cal_seen   <= n_cal_seen;
            r_cal_last   <= n_cal_last;
            r_cal_low    <= n_cal_low;
        end
    end

    // output register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_accept;
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (in_accept) begin
            r_skid <= n_res;
        end
    end

    `ASSERT_ALWAYS(a_skid_behind_out, !r_skid_valid || r_out_valid)
    `ASSERT_IMPLIES(a_exit_not_above_enter, r_out_valid, r_out.calc_exit <= r_out.calc_enter)
    `ASSERT_IMPLIES(a_lap_only_running, r_out_valid && r_out.lap_done, r_out.running)
    `ASSERT_ALWAYS(a_pass_count_bound, r_cal_cnt <= CNT_W'(CAL_PASSES))

endmodule

`default_nettype wire
